[hdl/lbtm_pkg.sv]
// Shared types, constants and the division step function of the throttle meter.
package lbtm_pkg;

   // Strip size and field widths
   localparam int MaxLeds  = 64;
   localparam int IdxW     = $clog2(MaxLeds);
   localparam int CntW     = IdxW + 1;
   localparam int ValW     = 11;
   localparam int ColW     = 8;
   localparam int GlowW    = 3 * ColW;
   localparam int DataW    = 32;
   localparam int AddrW    = 5;

   // Division: restoring steps done by one pipeline stage
   localparam int DivSteps     = 4;
   localparam int DivCntW      = $clog2(DivSteps + 1);
   localparam int DivTailSteps = ValW - 2 * DivSteps;
   localparam int ProdW        = ValW + ColW;

   // Strip modes
   typedef enum logic [1:0] {
      MODE_MIDDLE_OUT = 2'd0,
      MODE_FRONT_BACK = 2'd1,
      MODE_BACK_FRONT = 2'd2,
      MODE_UNDERGLOW  = 2'd3
   } mode_type;

   // Register indexes on the configuration port
   typedef enum logic [2:0] {
      REG_STRIP_MODE   = 3'd0,
      REG_LED_COUNT    = 3'd1,
      REG_GLOW_COLOR   = 3'd2,
      REG_CENTER_VALUE = 3'd3,
      REG_TOP_VALUE    = 3'd4
   } reg_index_type;

   // Register reset values
   localparam logic [CntW-1:0] LedCountReset = CntW'(16);
   localparam logic [ValW-1:0] CenterReset   = ValW'(992);
   localparam logic [ValW-1:0] TopReset      = ValW'(1811);
   localparam logic [ColW-1:0] LevelFull     = {ColW{1'b1}};

   // Input item
   typedef struct packed {
      logic [ValW-1:0] throttle;
      logic            system_enabled;
      logic            bar_enable;
      logic            glow_enable;
   } req_type;

   // Result item
   typedef struct packed {
      logic [IdxW-1:0] led_index;
      logic [ColW-1:0] red;
      logic [ColW-1:0] green;
      logic [ColW-1:0] blue;
      logic            last_led;
   } rsp_type;

   // Configuration registers as seen by the datapath
   typedef struct packed {
      mode_type         strip_mode;
      logic [CntW-1:0]  led_count;
      logic [GlowW-1:0] glow_color;
      logic [ValW-1:0]  center_value;
      logic [ValW-1:0]  top_value;
   } cfg_type;

   // Working registers of one restoring division
   typedef struct packed {
      logic [ValW-1:0] rem;
      logic [ValW-1:0] num;
      logic [ValW-1:0] quo;
      logic [ValW-1:0] den;
   } div_type;

   // Per-sample state carried down the pipeline
   typedef struct packed {
      mode_type        mode;
      logic [CntW-1:0] n;
      logic [IdxW-1:0] half;
      logic            below;
      logic            lit;
      logic            den_zero;
      logic [ValW-1:0] delta;
      logic [ValW-1:0] full;
      logic [ColW-1:0] partial;
      div_type         div;
   } work_type;

   // Up to DivSteps restoring division steps, one quotient bit each
   function automatic div_type div_run(div_type d, logic [DivCntW-1:0] count);
      div_type       r;
      logic [ValW:0] t;
      r = d;
      for (int i = 0; i < DivSteps; i++) begin
         if (DivCntW'(i) < count) begin
            t     = {r.rem, r.num[ValW-1]};
            r.num = {r.num[ValW-2:0], 1'b0};
            if (t >= {1'b0, r.den}) begin
               r.rem = ValW'(t - {1'b0, r.den});
               r.quo = {r.quo[ValW-2:0], 1'b1};
            end else begin
               r.rem = t[ValW-1:0];
               r.quo = {r.quo[ValW-2:0], 1'b0};
            end
         end
      end
      return r;
   endfunction

endpackage

[hdl/led_bar_graph_throttle_meter_unit.sv]
// Throttle bar-graph meter top level: register file, sample pipeline and LED walker.
//
// Each sample taken on start (while busy is low) yields one result per LED, led_count
// of them (at most 64), on consecutive cycles with rsp_strobe high, led_index counting
// from 0 and last_led on the final one; a count of zero yields none. The receiver cannot
// stall, so results stream out as soon as they are ready. A sample passes through the
// division pipeline stages (step, full-LED count and partial brightness, up to four
// quotient bits per stage) before the LED walker picks it up; the walker registers the
// sample and then each result in its output register. The walker emits one LED per
// cycle and takes the next sample while it forms the last LED of the current one; up to
// nine further samples queue in the pipeline meanwhile and busy rises once it is full.
// Configuration is to be written only while no sample is in flight.
module led_bar_graph_throttle_meter_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  lbtm_pkg::req_type           req_data,
   output logic                        rsp_strobe,
   output lbtm_pkg::rsp_type           rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [lbtm_pkg::AddrW-1:0]  paddr,
   input  logic [lbtm_pkg::DataW-1:0]  pwdata,
   output logic [lbtm_pkg::DataW-1:0]  prdata,
   output logic                        pready
);

   lbtm_pkg::cfg_type  cfg;
   lbtm_pkg::work_type item;
   logic               item_valid;
   logic               item_ready;

   // Configuration registers
   lbtm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Per-sample arithmetic
   lbtm_calc u_calc (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .cfg        (cfg),
      .busy       (busy),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready)
   );

   // Per-LED results
   lbtm_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

[hdl/lbtm_csr.sv]
// Configuration register file behind the APB-style port.
module lbtm_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [lbtm_pkg::AddrW-1:0]  paddr,
   input  logic [lbtm_pkg::DataW-1:0]  pwdata,
   output logic [lbtm_pkg::DataW-1:0]  prdata,
   output logic                        pready,
   output lbtm_pkg::cfg_type           cfg
);

   lbtm_pkg::cfg_type       cfg_ff;
   lbtm_pkg::reg_index_type reg_sel;
   logic                    wr_en;

   assign reg_sel = lbtm_pkg::reg_index_type'(paddr[lbtm_pkg::AddrW-1:2]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // Register writes on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strip_mode   <= lbtm_pkg::MODE_MIDDLE_OUT;
         cfg_ff.led_count    <= lbtm_pkg::LedCountReset;
         cfg_ff.glow_color   <= '0;
         cfg_ff.center_value <= lbtm_pkg::CenterReset;
         cfg_ff.top_value    <= lbtm_pkg::TopReset;
      end else if (wr_en) begin
         case (reg_sel)
            lbtm_pkg::REG_STRIP_MODE: begin
               cfg_ff.strip_mode <= lbtm_pkg::mode_type'(pwdata[1:0]);
            end
            lbtm_pkg::REG_LED_COUNT: begin
               cfg_ff.led_count <= pwdata[lbtm_pkg::CntW-1:0];
            end
            lbtm_pkg::REG_GLOW_COLOR: begin
               cfg_ff.glow_color <= pwdata[lbtm_pkg::GlowW-1:0];
            end
            lbtm_pkg::REG_CENTER_VALUE: begin
               cfg_ff.center_value <= pwdata[lbtm_pkg::ValW-1:0];
            end
            lbtm_pkg::REG_TOP_VALUE: begin
               cfg_ff.top_value <= pwdata[lbtm_pkg::ValW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Read-back
   always_comb begin
      case (reg_sel)
         lbtm_pkg::REG_STRIP_MODE:   prdata = lbtm_pkg::DataW'(cfg_ff.strip_mode);
         lbtm_pkg::REG_LED_COUNT:    prdata = lbtm_pkg::DataW'(cfg_ff.led_count);
         lbtm_pkg::REG_GLOW_COLOR:   prdata = lbtm_pkg::DataW'(cfg_ff.glow_color);
         lbtm_pkg::REG_CENTER_VALUE: prdata = lbtm_pkg::DataW'(cfg_ff.center_value);
         lbtm_pkg::REG_TOP_VALUE:    prdata = lbtm_pkg::DataW'(cfg_ff.top_value);
         default:                    prdata = '0;
      endcase
   end

endmodule

[hdl/lbtm_calc.sv]
// Sample pipeline: bar step, full LED count and partial brightness by staged division.
module lbtm_calc (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  lbtm_pkg::req_type   req_data,
   input  lbtm_pkg::cfg_type   cfg,
   output logic                busy,
   output logic                item_valid,
   output lbtm_pkg::work_type  item,
   input  logic                item_ready
);

   localparam int NumStages = 9;

   lbtm_pkg::work_type stage_ff [NumStages];
   lbtm_pkg::work_type stage_in [NumStages];
   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   logic [NumStages:0]   ready;
   logic                 accept;

   // Stall chain: a stage moves when it is empty or the next one moves
   always_comb begin
      ready[NumStages] = item_ready;
      for (int k = NumStages - 1; k >= 0; k--) begin
         ready[k] = ~valid_ff[k] | ready[k+1];
      end
   end

   assign busy       = ~ready[0];
   assign accept     = start & ready[0];
   assign item_valid = valid_ff[NumStages-1];
   assign item       = stage_ff[NumStages-1];

   always_comb begin
      valid_in[0] = accept;
      for (int k = 1; k < NumStages; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   // Stage transforms
   always_comb begin
      logic [lbtm_pkg::CntW-1:0]  n;
      logic [lbtm_pkg::IdxW-1:0]  half;
      logic [lbtm_pkg::CntW-1:0]  divisor;
      logic [lbtm_pkg::ValW-1:0]  span;
      logic [lbtm_pkg::ValW-1:0]  step;
      logic [lbtm_pkg::ProdW-1:0] prod;
      lbtm_pkg::div_type          d;

      // entry: clamp count, span, divisor, distance from centre
      n       = (cfg.led_count > lbtm_pkg::CntW'(lbtm_pkg::MaxLeds))
                ? lbtm_pkg::CntW'(lbtm_pkg::MaxLeds) : cfg.led_count;
      half    = n[lbtm_pkg::CntW-1:1];
      span    = (cfg.top_value > cfg.center_value)
                ? cfg.top_value - cfg.center_value : '0;
      divisor = (cfg.strip_mode == lbtm_pkg::MODE_MIDDLE_OUT)
                ? {1'b0, half} : n;

      stage_in[0].mode     = cfg.strip_mode;
      stage_in[0].n        = n;
      stage_in[0].half     = half;
      stage_in[0].below    = req_data.throttle < cfg.center_value;
      stage_in[0].lit      = req_data.system_enabled &
                             ((cfg.strip_mode == lbtm_pkg::MODE_UNDERGLOW)
                              ? req_data.glow_enable : req_data.bar_enable);
      stage_in[0].den_zero = (divisor == '0);
      stage_in[0].delta    = (req_data.throttle < cfg.center_value)
                             ? cfg.center_value - req_data.throttle
                             : req_data.throttle - cfg.center_value;
      stage_in[0].full     = '0;
      stage_in[0].partial  = '0;
      stage_in[0].div.rem  = '0;
      stage_in[0].div.num  = span;
      stage_in[0].div.quo  = '0;
      stage_in[0].div.den  = lbtm_pkg::ValW'(divisor);

      for (int k = 1; k < NumStages; k++) begin
         stage_in[k] = stage_ff[k-1];
      end

      // step = span / divisor
      stage_in[1].div = lbtm_pkg::div_run(stage_ff[0].div,
                                          lbtm_pkg::DivCntW'(lbtm_pkg::DivSteps));
      stage_in[2].div = lbtm_pkg::div_run(stage_ff[1].div,
                                          lbtm_pkg::DivCntW'(lbtm_pkg::DivSteps));
      d    = lbtm_pkg::div_run(stage_ff[2].div,
                               lbtm_pkg::DivCntW'(lbtm_pkg::DivTailSteps));
      // zero step saturates to one
      step = (stage_ff[2].den_zero || d.quo == '0) ? lbtm_pkg::ValW'(1) : d.quo;
      stage_in[3].div.rem = '0;
      stage_in[3].div.num = stage_ff[2].delta;
      stage_in[3].div.quo = '0;
      stage_in[3].div.den = step;

      // full = delta / step, remainder kept
      stage_in[4].div = lbtm_pkg::div_run(stage_ff[3].div,
                                          lbtm_pkg::DivCntW'(lbtm_pkg::DivSteps));
      stage_in[5].div = lbtm_pkg::div_run(stage_ff[4].div,
                                          lbtm_pkg::DivCntW'(lbtm_pkg::DivSteps));
      d    = lbtm_pkg::div_run(stage_ff[5].div,
                               lbtm_pkg::DivCntW'(lbtm_pkg::DivTailSteps));
      // 255 * rem as a shift and subtract; its top bits already sit below step
      prod = {d.rem, {lbtm_pkg::ColW{1'b0}}} - lbtm_pkg::ProdW'(d.rem);
      stage_in[6].full    = d.quo;
      stage_in[6].div.rem = prod[lbtm_pkg::ProdW-1:lbtm_pkg::ColW];
      stage_in[6].div.num = {prod[lbtm_pkg::ColW-1:0],
                             {(lbtm_pkg::ValW - lbtm_pkg::ColW){1'b0}}};
      stage_in[6].div.quo = '0;
      stage_in[6].div.den = d.den;

      // partial = 255 * rem / step, eight quotient bits
      stage_in[7].div = lbtm_pkg::div_run(stage_ff[6].div,
                                          lbtm_pkg::DivCntW'(lbtm_pkg::DivSteps));
      d = lbtm_pkg::div_run(stage_ff[7].div,
                            lbtm_pkg::DivCntW'(lbtm_pkg::DivSteps));
      stage_in[8].div     = d;
      stage_in[8].partial = d.quo[lbtm_pkg::ColW-1:0];
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NumStages; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      for (int k = 0; k < NumStages; k++) begin
         if (ready[k] && valid_in[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

endmodule

[hdl/lbtm_emit.sv]
// LED walker: one colour result per LED and cycle for the sample it holds.
module lbtm_emit (
   input  logic                clock,
   input  logic                reset,
   input  lbtm_pkg::cfg_type   cfg,
   input  logic                item_valid,
   input  lbtm_pkg::work_type  item,
   output logic                item_ready,
   output logic                rsp_strobe,
   output lbtm_pkg::rsp_type   rsp_data
);

   lbtm_pkg::work_type        cur_ff;
   logic [lbtm_pkg::IdxW-1:0] pos_ff;
   logic                      active_ff;
   logic                      rsp_strobe_ff;
   lbtm_pkg::rsp_type         rsp_data_ff;
   lbtm_pkg::rsp_type         rsp_data_in;
   logic                      last_now;
   logic                      take;

   assign last_now   = active_ff &&
                       ({1'b0, pos_ff} == cur_ff.n - lbtm_pkg::CntW'(1));
   assign take       = ~active_ff | last_now;
   assign item_ready = take;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // Colour of the LED at pos_ff
   always_comb begin
      logic [lbtm_pkg::CntW-1:0] p;
      logic [lbtm_pkg::CntW-1:0] bar_pos;
      logic                      in_bar;
      logic [lbtm_pkg::ColW-1:0] level;

      p       = {1'b0, pos_ff};
      bar_pos = p;
      in_bar  = 1'b1;
      case (cur_ff.mode)
         lbtm_pkg::MODE_MIDDLE_OUT: begin
            // mirrored halves; an odd last LED stays off
            if (p < {1'b0, cur_ff.half}) begin
               bar_pos = {1'b0, cur_ff.half} - p - lbtm_pkg::CntW'(1);
            end else if (p < {cur_ff.half, 1'b0}) begin
               bar_pos = p - {1'b0, cur_ff.half};
            end else begin
               in_bar = 1'b0;
            end
         end
         lbtm_pkg::MODE_FRONT_BACK: bar_pos = p;
         lbtm_pkg::MODE_BACK_FRONT: bar_pos = cur_ff.n - lbtm_pkg::CntW'(1) - p;
         default:                   in_bar  = 1'b0;
      endcase

      if (!in_bar) begin
         level = '0;
      end else if (lbtm_pkg::ValW'(bar_pos) < cur_ff.full) begin
         level = lbtm_pkg::LevelFull;
      end else if (lbtm_pkg::ValW'(bar_pos) == cur_ff.full) begin
         level = cur_ff.partial;
      end else begin
         level = '0;
      end

      rsp_data_in.led_index = pos_ff;
      rsp_data_in.last_led  = last_now;
      rsp_data_in.red       = '0;
      rsp_data_in.green     = '0;
      rsp_data_in.blue      = '0;
      if (cur_ff.lit) begin
         if (cur_ff.mode == lbtm_pkg::MODE_UNDERGLOW) begin
            rsp_data_in.red   = cfg.glow_color[3*lbtm_pkg::ColW-1:2*lbtm_pkg::ColW];
            rsp_data_in.green = cfg.glow_color[2*lbtm_pkg::ColW-1:lbtm_pkg::ColW];
            rsp_data_in.blue  = cfg.glow_color[lbtm_pkg::ColW-1:0];
         end else if (cur_ff.below) begin
            rsp_data_in.red   = level;
         end else begin
            rsp_data_in.green = level;
         end
      end
   end

   // Walker control and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= active_ff;
         if (take) begin
            // a sample with no LEDs is consumed without results
            active_ff <= item_valid && (item.n != '0);
         end
      end
   end

   // Walker payload and output register
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (take) begin
         pos_ff <= '0;
         if (item_valid) begin
            cur_ff <= item;
         end
      end else begin
         pos_ff <= pos_ff + lbtm_pkg::IdxW'(1);
      end
   end

endmodule

[hdl/lbtm_checker.sv]
// Port-level checks on the result stream of the throttle meter.
module lbtm_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_strobe,
   input lbtm_pkg::rsp_type rsp_data
);

   localparam int IdxW = lbtm_pkg::IdxW;

   // No result straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe after reset");

   // A run has no gaps until its last LED
   a_run_unbroken: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_led |=> rsp_strobe)
      else $error("result run broken before last LED");

   // LED index counts up by one within a run
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_led |=>
      rsp_data.led_index == IdxW'($past(rsp_data.led_index) + 1'b1))
      else $error("LED index not consecutive");

   // Each run starts at LED zero
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (!$past(rsp_strobe) || $past(rsp_data.last_led)) |->
      rsp_data.led_index == '0)
      else $error("run does not start at LED zero");

endmodule

bind led_bar_graph_throttle_meter_unit lbtm_checker u_lbtm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

[test/tb_led_bar_graph_throttle_meter_unit.sv]
// Self-checking testbench for the throttle bar-graph meter: directed table, then random samples.
`timescale 1ns / 1ps

module tb_led_bar_graph_throttle_meter_unit;
   import lbtm_pkg::*;

   // How the expected colours of one sample are obtained
   typedef enum logic [1:0] {
      OUT_PREDICTED = 2'd0,
      OUT_BLACK     = 2'd1,
      OUT_SOLID     = 2'd2
   } outcome_type;

   // One sample waiting to be offered, with its expectation source
   typedef struct packed {
      req_type          sample;
      outcome_type      kind;
      logic [GlowW-1:0] colour;
   } job_type;

   // One row of the directed table: register settings plus the sample
   typedef struct packed {
      cfg_type cfg;
      job_type job;
   } row_type;

   logic             clock;
   logic             reset   = 1'b1;
   logic             start   = 1'b0;
   logic             busy;
   req_type          req_data = '0;
   logic             rsp_strobe;
   rsp_type          rsp_data;
   logic             psel    = 1'b0;
   logic             penable = 1'b0;
   logic             pwrite  = 1'b0;
   logic [AddrW-1:0] paddr   = '0;
   logic [DataW-1:0] pwdata  = '0;
   logic [DataW-1:0] prdata;
   logic             pready;

   cfg_type     meter_cfg;
   job_type     pending_samples[$];
   rsp_type     expected_leds[$];
   row_type     directed_rows[$];
   int unsigned sender_idle_pct = 0;
   int unsigned fault_count     = 0;
   int unsigned samples_taken   = 0;
   int unsigned leds_checked    = 0;
   int unsigned settings_used   = 0;

   led_bar_graph_throttle_meter_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Number of LEDs actually driven, count above the strip maximum saturates
   function automatic int unsigned strip_length();
      return (meter_cfg.led_count > MaxLeds) ? MaxLeds : meter_cfg.led_count;
   endfunction

   // Expected colour of every LED for one sample under the current settings
   function automatic void predict_strip(req_type s);
      int unsigned n, half, span, divisor, stp, delta, full, partial, lvl, pos;
      bit          below, bar_on, in_bar;
      rsp_type     led;
      n       = strip_length();
      half    = n / 2;
      span    = (meter_cfg.top_value > meter_cfg.center_value) ?
                meter_cfg.top_value - meter_cfg.center_value : 0;
      divisor = (meter_cfg.strip_mode == MODE_MIDDLE_OUT) ? half : n;
      stp     = (divisor != 0) ? span / divisor : 0;
      if (stp == 0) begin
         stp = 1;
      end
      below   = s.throttle < meter_cfg.center_value;
      delta   = below ? meter_cfg.center_value - s.throttle
                      : s.throttle - meter_cfg.center_value;
      full    = delta / stp;
      partial = (LevelFull * (delta % stp)) / stp;
      bar_on  = s.system_enabled && s.bar_enable;
      for (int unsigned p = 0; p < n; p++) begin
         led           = '0;
         led.led_index = IdxW'(p);
         led.last_led  = (p + 1 == n);
         if (meter_cfg.strip_mode == MODE_UNDERGLOW) begin
            if (s.system_enabled && s.glow_enable) begin
               {led.red, led.green, led.blue} = meter_cfg.glow_color;
            end
         end else if (bar_on) begin
            in_bar = 1'b1;
            pos    = 0;
            case (meter_cfg.strip_mode)
               MODE_MIDDLE_OUT: begin
                  // halves mirror round the middle; odd last LED stays dark
                  if (p < half) pos = half - 1 - p;
                  else if (p < 2 * half) pos = p - half;
                  else in_bar = 1'b0;
               end
               MODE_FRONT_BACK: pos = p;
               default:         pos = n - 1 - p;
            endcase
            if (!in_bar) lvl = 0;
            else if (pos < full) lvl = LevelFull;
            else if (pos == full) lvl = partial;
            else lvl = 0;
            if (below) led.red = ColW'(lvl);
            else led.green = ColW'(lvl);
         end
         expected_leds.push_back(led);
      end
   endfunction

   // Sender: offers queued samples, predicts on each accepted transfer
   always @(posedge clock) begin
      job_type job;
      rsp_type led;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            job = pending_samples.pop_front();
            samples_taken++;
            if (job.kind == OUT_PREDICTED) begin
               predict_strip(job.sample);
            end else begin
               for (int unsigned p = 0; p < strip_length(); p++) begin
                  led           = '0;
                  led.led_index = IdxW'(p);
                  led.last_led  = (p + 1 == strip_length());
                  if (job.kind == OUT_SOLID) {led.red, led.green, led.blue} = job.colour;
                  expected_leds.push_back(led);
               end
            end
         end
         // hold an offered sample until taken; otherwise maybe idle
         if (start && busy) begin
            start <= 1'b1;
         end else if (pending_samples.size() != 0 &&
                      $urandom_range(99, 0) >= sender_idle_pct) begin
            start    <= 1'b1;
            req_data <= pending_samples[0].sample;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic flag_mismatch(string what);
      $display("[%0t] MISMATCH %s", $time, what);
      fault_count++;
   endtask

   // Result checker: every strobed LED against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && $isunknown(rsp_strobe)) begin
         flag_mismatch("rsp_strobe unknown");
      end else if (!reset && rsp_strobe) begin
         leds_checked++;
         if (expected_leds.size() == 0) begin
            flag_mismatch($sformatf("unexpected LED %0d", rsp_data.led_index));
         end else begin
            want = expected_leds.pop_front();
            if (rsp_data.led_index !== want.led_index)
               flag_mismatch($sformatf("led_index %0d, want %0d",
                                       rsp_data.led_index, want.led_index));
            if (rsp_data.red !== want.red)
               flag_mismatch($sformatf("LED %0d red %0d, want %0d",
                                       want.led_index, rsp_data.red, want.red));
            if (rsp_data.green !== want.green)
               flag_mismatch($sformatf("LED %0d green %0d, want %0d",
                                       want.led_index, rsp_data.green, want.green));
            if (rsp_data.blue !== want.blue)
               flag_mismatch($sformatf("LED %0d blue %0d, want %0d",
                                       want.led_index, rsp_data.blue, want.blue));
            if (rsp_data.last_led !== want.last_led)
               flag_mismatch($sformatf("LED %0d last_led %0b, want %0b",
                                       want.led_index, rsp_data.last_led, want.last_led));
         end
      end
   end

   // Wait for every sample taken and every LED seen, then let the pipeline empty
   task automatic settle_strip();
      while (pending_samples.size() != 0 || expected_leds.size() != 0) @(posedge clock);
      repeat (48) @(posedge clock);
   endtask

   // One register write: setup cycle, then access until pready
   task automatic csr_write(reg_index_type idx, logic [DataW-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= AddrW'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic apply_settings(cfg_type c);
      settle_strip();
      csr_write(REG_STRIP_MODE,   DataW'(c.strip_mode));
      csr_write(REG_LED_COUNT,    DataW'(c.led_count));
      csr_write(REG_GLOW_COLOR,   DataW'(c.glow_color));
      csr_write(REG_CENTER_VALUE, DataW'(c.center_value));
      csr_write(REG_TOP_VALUE,    DataW'(c.top_value));
      meter_cfg = c;
      settings_used++;
   endtask

   function automatic row_type mk_row(mode_type m, int cnt, int glow, int ctr, int top,
                                      int thr, bit sys, bit bar, bit gl,
                                      outcome_type k, int colour);
      row_type r;
      r.cfg.strip_mode            = m;
      r.cfg.led_count             = CntW'(cnt);
      r.cfg.glow_color            = GlowW'(glow);
      r.cfg.center_value          = ValW'(ctr);
      r.cfg.top_value             = ValW'(top);
      r.job.sample.throttle       = ValW'(thr);
      r.job.sample.system_enabled = sys;
      r.job.sample.bar_enable     = bar;
      r.job.sample.glow_enable    = gl;
      r.job.kind                  = k;
      r.job.colour                = GlowW'(colour);
      return r;
   endfunction

   // Stimulus
   initial begin
      cfg_type     c;
      job_type     job;
      int          centre, span, off, thr;
      int unsigned idle_steps[3];
      meter_cfg.strip_mode   = MODE_MIDDLE_OUT;
      meter_cfg.led_count    = LedCountReset;
      meter_cfg.glow_color   = '0;
      meter_cfg.center_value = CenterReset;
      meter_cfg.top_value    = TopReset;
      idle_steps = '{13, 61, 0};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // mode, count, glow, centre, top | throttle, sys, bar, glow | expectation
      directed_rows.push_back(mk_row(MODE_MIDDLE_OUT, 16, 0, 992, 1811,
                                     992, 1, 1, 0, OUT_BLACK, 0));          // at centre
      directed_rows.push_back(mk_row(MODE_MIDDLE_OUT, 16, 0, 992, 1811,
                                     2047, 1, 1, 0, OUT_SOLID, 'h00FF00));  // full forward
      directed_rows.push_back(mk_row(MODE_MIDDLE_OUT, 16, 0, 992, 1811,
                                     0, 1, 1, 0, OUT_SOLID, 'hFF0000));     // full reverse
      directed_rows.push_back(mk_row(MODE_MIDDLE_OUT, 16, 0, 992, 1811,
                                     1400, 1, 1, 1, OUT_PREDICTED, 0));
      directed_rows.push_back(mk_row(MODE_MIDDLE_OUT, 16, 0, 992, 1811,
                                     1400, 0, 1, 1, OUT_BLACK, 0));         // system off
      directed_rows.push_back(mk_row(MODE_MIDDLE_OUT, 16, 0, 992, 1811,
                                     1400, 1, 0, 1, OUT_BLACK, 0));         // bar off
      directed_rows.push_back(mk_row(MODE_FRONT_BACK, 16, 0, 992, 1811,
                                     1300, 1, 1, 0, OUT_PREDICTED, 0));
      directed_rows.push_back(mk_row(MODE_FRONT_BACK, 16, 0, 992, 1811,
                                     700, 1, 1, 0, OUT_PREDICTED, 0));
      directed_rows.push_back(mk_row(MODE_BACK_FRONT, 16, 0, 992, 1811,
                                     1300, 1, 1, 0, OUT_PREDICTED, 0));
      directed_rows.push_back(mk_row(MODE_BACK_FRONT, 16, 0, 992, 1811,
                                     500, 1, 1, 0, OUT_PREDICTED, 0));
      directed_rows.push_back(mk_row(MODE_UNDERGLOW, 64, 'hFFFFFF, 992, 1811,
                                     0, 1, 0, 1, OUT_SOLID, 'hFFFFFF));
      directed_rows.push_back(mk_row(MODE_UNDERGLOW, 64, 'h123456, 992, 1811,
                                     2047, 0, 1, 1, OUT_BLACK, 0));         // system off
      directed_rows.push_back(mk_row(MODE_UNDERGLOW, 64, 'h123456, 992, 1811,
                                     1000, 1, 1, 0, OUT_BLACK, 0));         // glow off
      directed_rows.push_back(mk_row(MODE_UNDERGLOW, 127, 'hA5C35A, 992, 1811,
                                     1000, 1, 0, 1, OUT_SOLID, 'hA5C35A));  // count saturates
      directed_rows.push_back(mk_row(MODE_MIDDLE_OUT, 0, 0, 992, 1811,
                                     1500, 1, 1, 1, OUT_BLACK, 0));         // no LEDs at all
      directed_rows.push_back(mk_row(MODE_MIDDLE_OUT, 1, 0, 992, 1811,
                                     1500, 1, 1, 1, OUT_PREDICTED, 0));
      directed_rows.push_back(mk_row(MODE_MIDDLE_OUT, 7, 0, 992, 1811,
                                     1500, 1, 1, 0, OUT_PREDICTED, 0));     // odd count
      directed_rows.push_back(mk_row(MODE_FRONT_BACK, 64, 0, 1000, 0,
                                     1003, 1, 1, 0, OUT_PREDICTED, 0));     // top under centre
      directed_rows.push_back(mk_row(MODE_FRONT_BACK, 2, 0, 0, 2047,
                                     2047, 1, 1, 0, OUT_PREDICTED, 0));
      directed_rows.push_back(mk_row(MODE_FRONT_BACK, 64, 0, 2047, 2047,
                                     0, 1, 1, 0, OUT_SOLID, 'hFF0000));     // zero span
      directed_rows.push_back(mk_row(MODE_BACK_FRONT, 3, 0, 1024, 1030,
                                     1027, 1, 1, 0, OUT_PREDICTED, 0));
      directed_rows.push_back(mk_row(MODE_MIDDLE_OUT, 64, 0, 0, 2047,
                                     1000, 1, 1, 0, OUT_PREDICTED, 0));
      directed_rows.push_back(mk_row(MODE_MIDDLE_OUT, 127, 0, 1024, 1500,
                                     1100, 1, 1, 0, OUT_PREDICTED, 0));
      directed_rows.push_back(mk_row(MODE_MIDDLE_OUT, 2, 0, 992, 1811,
                                     991, 1, 1, 0, OUT_PREDICTED, 0));

      // Directed table, registers rewritten only when a row changes them
      foreach (directed_rows[i]) begin
         if (directed_rows[i].cfg != meter_cfg) apply_settings(directed_rows[i].cfg);
         pending_samples.push_back(directed_rows[i].job);
      end

      // Random part: three idling regimes, four register settings each
      foreach (idle_steps[k]) begin
         for (int ph = 0; ph < 4; ph++) begin
            c.strip_mode = mode_type'($urandom_range(3, 0));
            case ($urandom_range(19, 0))
               0:       c.led_count = CntW'($urandom_range(127, 65));
               1:       c.led_count = CntW'($urandom_range(1, 0));
               default: c.led_count = CntW'($urandom_range(64, 2));
            endcase
            c.glow_color   = GlowW'($urandom);
            c.center_value = ValW'($urandom_range(2047, 0));
            if ($urandom_range(3, 0) == 0)
               c.top_value = ValW'($urandom_range(2047, 0));
            else
               c.top_value = ValW'(c.center_value + $urandom_range(2047 - c.center_value, 0));
            apply_settings(c);
            sender_idle_pct = idle_steps[k];
            centre = meter_cfg.center_value;
            span   = (meter_cfg.top_value > meter_cfg.center_value) ?
                     meter_cfg.top_value - meter_cfg.center_value : 0;
            for (int j = 0; j < 30; j++) begin
               // mostly throttle within the bar span, some anywhere
               if ($urandom_range(3, 0) == 0) begin
                  thr = $urandom_range(2047, 0);
               end else begin
                  off = $urandom_range(span + span / 4 + 8, 0);
                  thr = $urandom_range(1, 0) ? centre + off : centre - off;
                  thr = (thr < 0) ? 0 : (thr > 2047) ? 2047 : thr;
               end
               job.sample.throttle       = ValW'(thr);
               job.sample.system_enabled = ($urandom_range(9, 0) != 0);
               job.sample.bar_enable     = ($urandom_range(6, 0) != 0);
               job.sample.glow_enable    = ($urandom_range(6, 0) != 0);
               job.kind                  = OUT_PREDICTED;
               job.colour                = '0;
               pending_samples.push_back(job);
            end
            settle_strip();
         end
      end

      settle_strip();
      $display("Run covered %0d samples under %0d register settings, %0d LEDs compared.",
               samples_taken, settings_used, leds_checked);
      $display("All four strip modes, sender idling at 13, 61 and 0 percent.");
      if (fault_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: well beyond the slowest legal run
   initial begin
      #(5_000_000);
      $display("Timed out with %0d LEDs still expected.", expected_leds.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
